### design/lpr_pkg.sv
// Shared types, constants and tables for the lidar point to range pixel block.
package lpr_pkg;

	// Geometry limits.
	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 2048;
	localparam int ROW_W = $clog2(MAX_ROWS + 1);
	localparam int COL_W = $clog2(MAX_COLS + 1);

	// Field widths.
	localparam int COORD_W = 24;
	localparam int SQ_W = 2 * COORD_W;

	// Configuration port.
	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	// Angles are held in 1/65536 degree; registers in 1/1024 degree.
	localparam int ANG_SHIFT = 6;
	localparam int QUARTER_TURN = 90 * 65536;
	localparam int PIXEL_SCALE2 = 2 * 127500;
	localparam int PIXEL_MAX = 255;

	// CORDIC vectoring unit.
	localparam int CORDIC_STEPS = 23;
	localparam int CORDIC_LAT = CORDIC_STEPS + 1;
	localparam int CIN_W = 33;
	localparam int CW = 36;
	localparam int ZW = 26;
	localparam logic [21:0] ANGLE_TAB [CORDIC_STEPS] = '{
		22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
		22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833, 22'd917,
		22'd458, 22'd229, 22'd115, 22'd57, 22'd29, 22'd14, 22'd7, 22'd4, 22'd2, 22'd1
	};

	// Square root unit.
	localparam int SQRT_IN_W = 64;
	localparam int SQRT_OUT_W = 32;
	localparam int SQRT_LAT = SQRT_OUT_W;

	// Divider unit.
	localparam int DIV_NW = 26;
	localparam int DIV_DW = 25;
	localparam int DIV_QW = 12;
	localparam int DIV_LAT = DIV_QW + 1;

	typedef enum logic [2:0] {
		REG_RING_ROWS     = 3'd0,
		REG_IMAGE_COLUMNS = 3'd1,
		REG_COLUMN_STEP   = 3'd2,
		REG_ROW_STEP      = 3'd3,
		REG_BOTTOM_ANGLE  = 3'd4,
		REG_AZIMUTH_LOW   = 3'd5,
		REG_AZIMUTH_HIGH  = 3'd6,
		REG_NEAR_LIMIT    = 3'd7
	} reg_index_t;

	typedef enum logic [2:0] {
		VERDICT_KEPT     = 3'd0,
		VERDICT_ROW_OUT  = 3'd1,
		VERDICT_AZIMUTH  = 3'd2,
		VERDICT_COL_OUT  = 3'd3,
		VERDICT_TOO_NEAR = 3'd4
	} verdict_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
	} point_t;

	typedef struct packed {
		logic [2:0]  verdict;
		logic [5:0]  pixel_row;
		logic [10:0] pixel_col;
		logic [7:0]  pixel_value;
	} pixel_t;

	typedef struct packed {
		logic [6:0]         ring_rows;
		logic [11:0]        image_columns;
		logic [15:0]        column_step;
		logic [15:0]        row_step;
		logic [16:0]        bottom_angle;
		logic signed [18:0] azimuth_low;
		logic signed [18:0] azimuth_high;
		logic [15:0]        near_limit;
	} cfg_t;

endpackage

### design/lpr_regs.sv
// Configuration register bank behind the APB-style port.
module lpr_regs
	import lpr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	reg_index_t idx;

	assign idx = reg_index_t'(paddr[APB_AW-1:2]);
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ring_rows     <= 7'd16;
			cfg_q.image_columns <= 12'd1800;
			cfg_q.column_step   <= 16'd205;
			cfg_q.row_step      <= 16'd2048;
			cfg_q.bottom_angle  <= 17'd15462;
			cfg_q.azimuth_low   <= -19'sd184320;
			cfg_q.azimuth_high  <= 19'sd184320;
			cfg_q.near_limit    <= 16'd2500;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_RING_ROWS:     cfg_q.ring_rows     <= pwdata[6:0];
				REG_IMAGE_COLUMNS: cfg_q.image_columns <= pwdata[11:0];
				REG_COLUMN_STEP:   cfg_q.column_step   <= pwdata[15:0];
				REG_ROW_STEP:      cfg_q.row_step      <= pwdata[15:0];
				REG_BOTTOM_ANGLE:  cfg_q.bottom_angle  <= pwdata[16:0];
				REG_AZIMUTH_LOW:   cfg_q.azimuth_low   <= $signed(pwdata[18:0]);
				REG_AZIMUTH_HIGH:  cfg_q.azimuth_high  <= $signed(pwdata[18:0]);
				REG_NEAR_LIMIT:    cfg_q.near_limit    <= pwdata[15:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_RING_ROWS:     prdata = APB_DW'(cfg_q.ring_rows);
			REG_IMAGE_COLUMNS: prdata = APB_DW'(cfg_q.image_columns);
			REG_COLUMN_STEP:   prdata = APB_DW'(cfg_q.column_step);
			REG_ROW_STEP:      prdata = APB_DW'(cfg_q.row_step);
			REG_BOTTOM_ANGLE:  prdata = APB_DW'(cfg_q.bottom_angle);
			REG_AZIMUTH_LOW:   prdata = APB_DW'($unsigned(cfg_q.azimuth_low));
			REG_AZIMUTH_HIGH:  prdata = APB_DW'($unsigned(cfg_q.azimuth_high));
			REG_NEAR_LIMIT:    prdata = APB_DW'(cfg_q.near_limit);
		endcase
	end

endmodule

### design/lpr_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module lpr_isqrt
	import lpr_pkg::*;
(
	input  logic                  clk,
	input  logic                  en,
	input  logic [SQRT_IN_W-1:0]  value,
	output logic [SQRT_OUT_W-1:0] root
);

	logic [SQRT_IN_W-1:0] rem_s  [SQRT_LAT];
	logic [SQRT_IN_W-1:0] root_s [SQRT_LAT];

	for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
		logic [SQRT_IN_W-1:0] rem_i, root_i, bit_k;
		logic [SQRT_IN_W:0]   trial;

		if (k == 0) begin : g_first
			assign rem_i  = value;
			assign root_i = '0;
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
		end

		assign bit_k = SQRT_IN_W'(1) << (SQRT_IN_W - 2 - 2 * k);
		assign trial = {1'b0, root_i} + {1'b0, bit_k};

		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, rem_i} >= trial) begin
					rem_s[k]  <= rem_i - trial[SQRT_IN_W-1:0];
					root_s[k] <= (root_i >> 1) + bit_k;
				end else begin
					rem_s[k]  <= rem_i;
					root_s[k] <= root_i >> 1;
				end
			end
		end
	end

	assign root = root_s[SQRT_LAT-1][SQRT_OUT_W-1:0];

endmodule

### design/lpr_cordic.sv
// Pipelined CORDIC in vectoring mode: angle of (den, num) in 1/65536 degree.
module lpr_cordic
	import lpr_pkg::*;
(
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [CIN_W-1:0] num,
	input  logic signed [CIN_W-1:0] den,
	output logic signed [ZW-1:0]    angle
);

	logic signed [CW-1:0] num_s  [CORDIC_STEPS+1];
	logic signed [CW-1:0] den_s  [CORDIC_STEPS+1];
	logic signed [ZW-1:0] z_s    [CORDIC_STEPS+1];
	logic                 zero_s [CORDIC_STEPS+1];

	logic signed [CW-1:0] n_ext, d_ext;

	assign n_ext = CW'(num);
	assign d_ext = CW'(den);

	// A negative den is first turned by a quarter so the iterations converge.
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (num == '0) && (den == '0);
			if (d_ext < 0) begin
				if (n_ext >= 0) begin
					num_s[0] <= -d_ext;
					den_s[0] <= n_ext;
					z_s[0]   <= ZW'(QUARTER_TURN);
				end else begin
					num_s[0] <= d_ext;
					den_s[0] <= -n_ext;
					z_s[0]   <= -ZW'(QUARTER_TURN);
				end
			end else begin
				num_s[0] <= n_ext;
				den_s[0] <= d_ext;
				z_s[0]   <= '0;
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
		localparam logic signed [ZW-1:0] STEP = ZW'(ANGLE_TAB[i]);
		logic pos;

		assign pos = !num_s[i][CW-1] && (num_s[i] != '0);

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (pos) begin
					den_s[i+1] <= den_s[i] + (num_s[i] >>> i);
					num_s[i+1] <= num_s[i] - (den_s[i] >>> i);
					z_s[i+1]   <= z_s[i] + STEP;
				end else begin
					den_s[i+1] <= den_s[i] - (num_s[i] >>> i);
					num_s[i+1] <= num_s[i] + (den_s[i] >>> i);
					z_s[i+1]   <= z_s[i] - STEP;
				end
			end
		end
	end

	assign angle = zero_s[CORDIC_STEPS] ? '0 : z_s[CORDIC_STEPS];

endmodule

### design/lpr_divider.sv
// Pipelined restoring divider with a saturating quotient and overflow flag.
module lpr_divider
	import lpr_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [DIV_NW-1:0] num,
	input  logic [DIV_DW-1:0] den,
	output logic [DIV_QW-1:0] quot,
	output logic              ovf
);

	localparam int CMP_W = DIV_DW + DIV_QW;

	logic [DIV_NW-1:0] rem_s [DIV_QW+1];
	logic [DIV_DW-1:0] den_s [DIV_QW+1];
	logic [DIV_QW-1:0] q_s   [DIV_QW+1];
	logic              ovf_s [DIV_QW+1];

	// The quotient would not fit (this also covers a zero divisor).
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			den_s[0] <= den;
			q_s[0]   <= '0;
			ovf_s[0] <= CMP_W'(num) >= (CMP_W'(den) << DIV_QW);
		end
	end

	for (genvar k = 0; k < DIV_QW; k++) begin : g_bit
		localparam int B = DIV_QW - 1 - k;
		logic [CMP_W-1:0] cand;

		assign cand = CMP_W'(den_s[k]) << B;

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k+1] <= den_s[k];
				ovf_s[k+1] <= ovf_s[k];
				if (CMP_W'(rem_s[k]) >= cand) begin
					rem_s[k+1] <= rem_s[k] - cand[DIV_NW-1:0];
					q_s[k+1]   <= q_s[k] | (DIV_QW'(1) << B);
				end else begin
					rem_s[k+1] <= rem_s[k];
					q_s[k+1]   <= q_s[k];
				end
			end
		end
	end

	assign quot = q_s[DIV_QW];
	assign ovf  = ovf_s[DIV_QW];

endmodule

### design/lidar_point_to_range_pixel.sv
// Throughput: one word per cycle while the output is not stalled; a 32-stage square root,
// two 24-stage CORDICs and three 13-stage dividers are fully pipelined and all advance together.
// A stalled output word freezes the whole pipeline, so nothing is lost or repeated.
// Reset clears all valid bits and loads the configuration registers with defaults.
module lidar_point_to_range_pixel
	import lpr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              point_valid,
	output logic              point_stall,
	input  point_t            point,
	output logic              pixel_valid,
	input  logic              pixel_stall,
	output pixel_t            pixel,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic [COORD_W-1:0]        m;
		logic                      near;
	} side_a_t;

	typedef struct packed {
		logic [COORD_W-1:0] m;
		logic               near;
	} side_b_t;

	typedef struct packed {
		logic row_bad;
		logic e_neg;
		logic az_out;
		logic d_neg;
		logic near;
	} side_c_t;

	cfg_t cfg;
	logic en;

	// Configuration values in the form the datapath uses.
	logic [ROW_W-1:0]  rows_q;
	logic [COL_W-1:0]  cols_q;
	logic [21:0]       rstep_q, cstep_q;
	logic [31:0]       near2_q;
	logic [22:0]       bottom64_q;
	logic signed [24:0] low64_q, high64_q;

	lpr_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	always_ff @(posedge clk) begin
		rows_q     <= (cfg.ring_rows > ROW_W'(MAX_ROWS)) ? ROW_W'(MAX_ROWS) : cfg.ring_rows;
		cols_q     <= (cfg.image_columns > COL_W'(MAX_COLS)) ? COL_W'(MAX_COLS)
			: cfg.image_columns;
		rstep_q    <= {((cfg.row_step == '0) ? 16'd1 : cfg.row_step), 6'b0};
		cstep_q    <= {((cfg.column_step == '0) ? 16'd1 : cfg.column_step), 6'b0};
		near2_q    <= 32'(cfg.near_limit) * 32'(cfg.near_limit);
		bottom64_q <= {cfg.bottom_angle, 6'b0};
		low64_q    <= $signed({cfg.azimuth_low, 6'b0});
		high64_q   <= $signed({cfg.azimuth_high, 6'b0});
	end

	logic valid_s75;
	assign en = !(valid_s75 && pixel_stall);
	assign point_stall = !en;

	// Front end: magnitudes, squares, planar and full range tests.
	logic valid_s1, valid_s2, valid_s3;
	logic signed [COORD_W-1:0] x_s1, y_s1, z_s1, x_s2, y_s2, z_s2, x_s3, y_s3, z_s3;
	logic [COORD_W-1:0] ax_s1, ay_s1, az_s1, m_s1, m_s2, m_s3, ax_c, ay_c;
	logic [SQ_W-1:0]    ax2_s2, ay2_s2, az2_s2, planar2_s3;
	logic               near_s3;

	assign ax_c = point.pos_x[COORD_W-1] ? COORD_W'(-point.pos_x) : COORD_W'(point.pos_x);
	assign ay_c = point.pos_y[COORD_W-1] ? COORD_W'(-point.pos_y) : COORD_W'(point.pos_y);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= point.pos_x;
			y_s1   <= point.pos_y;
			z_s1   <= point.pos_z;
			ax_s1  <= ax_c;
			ay_s1  <= ay_c;
			az_s1  <= point.pos_z[COORD_W-1] ? COORD_W'(-point.pos_z)
				: COORD_W'(point.pos_z);
			m_s1   <= (ax_c > ay_c) ? ax_c : ay_c;
			x_s2   <= x_s1;
			y_s2   <= y_s1;
			z_s2   <= z_s1;
			m_s2   <= m_s1;
			ax2_s2 <= SQ_W'(ax_s1) * SQ_W'(ax_s1);
			ay2_s2 <= SQ_W'(ay_s1) * SQ_W'(ay_s1);
			az2_s2 <= SQ_W'(az_s1) * SQ_W'(az_s1);
			x_s3   <= x_s2;
			y_s3   <= y_s2;
			z_s3   <= z_s2;
			m_s3   <= m_s2;
			planar2_s3 <= ax2_s2 + ay2_s2;
			near_s3 <= ((SQ_W+1)'(ax2_s2) + (SQ_W+1)'(ay2_s2) + (SQ_W+1)'(az2_s2))
				< (SQ_W+1)'(near2_q);
		end
	end

	// Square root of the planar distance, with the rest of the word alongside.
	logic [SQRT_OUT_W-1:0] planar;
	side_a_t               side_a_q [SQRT_LAT];
	logic [SQRT_LAT-1:0]   va_q;

	lpr_isqrt u_isqrt (
		.clk, .en,
		.value({planar2_s3, 16'b0}),
		.root (planar)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_a_q[0] <= '{x: x_s3, y: y_s3, z: z_s3, m: m_s3, near: near_s3};
			for (int k = 1; k < SQRT_LAT; k++) side_a_q[k] <= side_a_q[k-1];
		end
	end

	// Elevation and azimuth angles.
	side_a_t               sa;
	logic signed [ZW-1:0]  elev, azim;
	side_b_t               side_b_q [CORDIC_LAT];
	logic [CORDIC_LAT-1:0] vb_q;

	assign sa = side_a_q[SQRT_LAT-1];

	lpr_cordic u_elev (
		.clk, .en,
		.num  (CIN_W'($signed({sa.z, 8'b0}))),
		.den  ($signed({1'b0, planar})),
		.angle(elev)
	);

	lpr_cordic u_azim (
		.clk, .en,
		.num  (CIN_W'($signed({sa.x, 8'b0}))),
		.den  (CIN_W'($signed({sa.y, 8'b0}))),
		.angle(azim)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_b_q[0] <= '{m: sa.m, near: sa.near};
			for (int k = 1; k < CORDIC_LAT; k++) side_b_q[k] <= side_b_q[k-1];
		end
	end

	// Offset elevation, column distance from the quarter turn, azimuth window.
	side_b_t               sb;
	logic                  valid_s60, valid_s61;
	logic signed [ZW-1:0]  e_s60, d_c;
	logic [ZW-2:0]         a_s60;
	logic                  d_neg_s60, az_out_s60, near_s60, near_s61;
	logic [COORD_W-1:0]    m_s60;

	assign sb  = side_b_q[CORDIC_LAT-1];
	assign d_c = azim - ZW'(QUARTER_TURN);

	always_ff @(posedge clk) begin
		if (en) begin
			e_s60      <= elev + $signed({3'b0, bottom64_q});
			a_s60      <= d_c[ZW-1] ? (ZW-1)'(-d_c) : (ZW-1)'(d_c);
			d_neg_s60  <= d_c[ZW-1];
			az_out_s60 <= (azim < ZW'(low64_q)) || (azim > ZW'(high64_q));
			m_s60      <= sb.m;
			near_s60   <= sb.near;
		end
	end

	// Divider operands.
	logic [DIV_NW-1:0] ring_num_s61, col_num_s61, pix_num_s61;
	logic [DIV_DW-1:0] ring_den_s61, col_den_s61, pix_den_s61;
	logic              row_bad_s61, e_neg_s61, az_out_s61, d_neg_s61;

	always_ff @(posedge clk) begin
		if (en) begin
			e_neg_s61    <= e_s60[ZW-1];
			row_bad_s61  <= e_s60[ZW-1] && ((-e_s60) >= $signed({4'b0, rstep_q}));
			ring_num_s61 <= e_s60[ZW-1] ? '0 : DIV_NW'(e_s60);
			ring_den_s61 <= DIV_DW'(rstep_q);
			col_num_s61  <= DIV_NW'({1'b0, a_s60, 1'b0} + (DIV_NW+1)'(cstep_q));
			col_den_s61  <= DIV_DW'({cstep_q, 1'b0});
			pix_num_s61  <= DIV_NW'(PIXEL_SCALE2) + DIV_NW'(m_s60);
			pix_den_s61  <= DIV_DW'({m_s60, 1'b0});
			az_out_s61   <= az_out_s60;
			d_neg_s61    <= d_neg_s60;
			near_s61     <= near_s60;
		end
	end

	logic [DIV_QW-1:0] ring_q, col_q, pix_q;
	logic              ring_ovf, col_ovf, pix_ovf;

	lpr_divider u_ring_div (
		.clk, .en, .num(ring_num_s61), .den(ring_den_s61), .quot(ring_q), .ovf(ring_ovf)
	);
	lpr_divider u_col_div (
		.clk, .en, .num(col_num_s61), .den(col_den_s61), .quot(col_q), .ovf(col_ovf)
	);
	lpr_divider u_pix_div (
		.clk, .en, .num(pix_num_s61), .den(pix_den_s61), .quot(pix_q), .ovf(pix_ovf)
	);

	side_c_t            side_c_q [DIV_LAT];
	logic [DIV_LAT-1:0] vc_q;

	always_ff @(posedge clk) begin
		if (en) begin
			side_c_q[0] <= '{row_bad: row_bad_s61, e_neg: e_neg_s61, az_out: az_out_s61,
				d_neg: d_neg_s61, near: near_s61};
			for (int k = 1; k < DIV_LAT; k++) side_c_q[k] <= side_c_q[k-1];
		end
	end

	// Final checks in order: row, azimuth, column, range.
	side_c_t             sc;
	logic [DIV_QW-1:0]   ring;
	logic                row_out, col_out;
	logic signed [14:0]  half, col_raw, col_wrap, cols_s;
	logic [7:0]          pix_val;
	pixel_t              word_c, pixel_s75;

	assign sc      = side_c_q[DIV_LAT-1];
	assign ring    = sc.e_neg ? '0 : ring_q;
	assign row_out = sc.row_bad || (!sc.e_neg && ring_ovf) || (ring >= DIV_QW'(rows_q));
	assign half    = $signed(15'(cols_q >> 1));
	assign cols_s  = $signed(15'(cols_q));
	assign col_raw = sc.d_neg ? half + $signed(15'(col_q)) : half - $signed(15'(col_q));
	assign col_wrap = (col_raw >= cols_s) ? col_raw - cols_s : col_raw;
	assign col_out = col_ovf || (col_wrap < 0) || (col_wrap >= cols_s);
	assign pix_val = (pix_ovf || pix_q > DIV_QW'(PIXEL_MAX)) ? 8'(PIXEL_MAX) : pix_q[7:0];

	always_comb begin
		word_c = '0;
		priority if (row_out) begin
			word_c.verdict = VERDICT_ROW_OUT;
		end else if (sc.az_out) begin
			word_c.verdict = VERDICT_AZIMUTH;
		end else if (col_out) begin
			word_c.verdict = VERDICT_COL_OUT;
		end else if (sc.near) begin
			word_c.verdict = VERDICT_TOO_NEAR;
		end else begin
			word_c.verdict     = VERDICT_KEPT;
			word_c.pixel_row   = 6'(rows_q - ROW_W'(1) - ring[ROW_W-1:0]);
			word_c.pixel_col   = col_wrap[10:0];
			word_c.pixel_value = pix_val;
		end
	end

	always_ff @(posedge clk) begin
		if (en) pixel_s75 <= word_c;
	end

	// Valid bits, travelling with the words above.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			va_q      <= '0;
			vb_q      <= '0;
			valid_s60 <= 1'b0;
			valid_s61 <= 1'b0;
			vc_q      <= '0;
			valid_s75 <= 1'b0;
		end else if (en) begin
			valid_s1  <= point_valid;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			va_q      <= {va_q[SQRT_LAT-2:0], valid_s3};
			vb_q      <= {vb_q[CORDIC_LAT-2:0], va_q[SQRT_LAT-1]};
			valid_s60 <= vb_q[CORDIC_LAT-1];
			valid_s61 <= valid_s60;
			vc_q      <= {vc_q[DIV_LAT-2:0], valid_s61};
			valid_s75 <= vc_q[DIV_LAT-1];
		end
	end

	assign pixel_valid = valid_s75;
	assign pixel       = pixel_s75;

endmodule
